[rtl/lmfr_pkg.sv]
// ----------------------------------------------------------------------------
// lmfr_pkg
// Shared types and constants for the log message framer with resync.
// ----------------------------------------------------------------------------
package lmfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 16;
  localparam int LEN_W      = 32;
  localparam int OUT_CNT_W  = 32;
  localparam int MAX_BEATS  = 4;
  localparam int BEAT_CNT_W = 2;

  // file header: four magic bytes then twelve more
  localparam logic [LEN_W-1:0] FILE_HDR_LEN = 32'd16;
  localparam logic [LEN_W-1:0] MAGIC_LEN    = 32'd4;
  // magic bytes, byte 0 in the low lane
  localparam logic [4*BYTE_W-1:0] MAGIC_WORD = 32'h676F_4C55;

  // bytes held before the type letter of a message header
  localparam logic [1:0] PEND_FULL = 2'd2;

  // end status codes
  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_CLEAN_END = 3'd1,
    ST_SHORT_TAIL = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_BAD_MAGIC = 3'd4,
    ST_TOO_SHORT = 3'd5
  } status_t;

  // message type letters
  localparam logic [BYTE_W-1:0] T_A = 8'h41;
  localparam logic [BYTE_W-1:0] T_B = 8'h42;
  localparam logic [BYTE_W-1:0] T_C = 8'h43;
  localparam logic [BYTE_W-1:0] T_D = 8'h44;
  localparam logic [BYTE_W-1:0] T_F = 8'h46;
  localparam logic [BYTE_W-1:0] T_I = 8'h49;
  localparam logic [BYTE_W-1:0] T_L = 8'h4C;
  localparam logic [BYTE_W-1:0] T_M = 8'h4D;
  localparam logic [BYTE_W-1:0] T_O = 8'h4F;
  localparam logic [BYTE_W-1:0] T_P = 8'h50;
  localparam logic [BYTE_W-1:0] T_Q = 8'h51;
  localparam logic [BYTE_W-1:0] T_R = 8'h52;
  localparam logic [BYTE_W-1:0] T_S = 8'h53;

  // payload size rules
  localparam logic [SIZE_W-1:0] SIZE_B_EQ    = 16'd40;
  localparam logic [SIZE_W-1:0] SIZE_C_MIN   = 16'd14;
  localparam logic [SIZE_W-1:0] SIZE_D_MIN   = 16'd4;
  localparam logic [SIZE_W-1:0] SIZE_L_MIN   = 16'd10;
  localparam logic [SIZE_W-1:0] SIZE_O_EQ    = 16'd2;
  localparam logic [SIZE_W-1:0] SIZE_R_EQ    = 16'd2;
  localparam logic [SIZE_W-1:0] SIZE_S_EQ    = 16'd8;
  localparam logic [SIZE_W-1:0] SIZE_DEF_MIN = 16'd6;

  // header check result
  typedef struct packed {
    logic ok;        // type and size pass the section rules
    logic defs_nxt;  // definitions section flag after this header
  } hdr_chk_t;

  function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
    magic_byte = MAGIC_WORD[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

[rtl/lmfr_in_if.sv]
// ----------------------------------------------------------------------------
// lmfr_in_if
// Input byte channel: valid/ready with one file byte and a restart flag.
// ----------------------------------------------------------------------------
interface lmfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, data_byte, first, input ready);
  modport sink (input valid, data_byte, first, output ready);
endinterface

[rtl/lmfr_out_if.sv]
// ----------------------------------------------------------------------------
// lmfr_out_if
// Result channel: valid/ready with one result beat.
// ----------------------------------------------------------------------------
interface lmfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        message_start;
  logic [7:0]  message_kind;
  logic        skipped;
  logic [2:0]  status;
  logic [31:0] msg_count;
  logic [31:0] skip_count;
  logic        last;

  modport source (output valid, out_byte, byte_valid, message_start, message_kind,
                  skipped, status, msg_count, skip_count, last,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, message_start, message_kind,
                skipped, status, msg_count, skip_count, last,
                output ready);
endinterface

[rtl/lmfr_cfg_if.sv]
// ----------------------------------------------------------------------------
// lmfr_cfg_if
// Configuration write channel: valid/ready with the file length.
// ----------------------------------------------------------------------------
interface lmfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_length;

  modport source (output valid, total_length, input ready);
  modport sink (input valid, total_length, output ready);
endinterface

[rtl/log_message_framer_resync.sv]
// ----------------------------------------------------------------------------
// log_message_framer_resync
// Byte-serial framer for a log file: checks the file magic, frames messages
// from their 3-byte headers, drops one byte and rescans on a bad header.
// ----------------------------------------------------------------------------
// latency: first result beat of a byte is valid the cycle after it is accepted
// throughput: one input byte per cycle while each byte yields one beat and results
//   are taken; a byte yielding n beats (3 for an accepted header, 4 for the
//   magic release) holds the input until the result register has sent them all
// reset: synchronous rst_n clears parse state, counters, total_length and the
//   result valid; no clearing pass
module log_message_framer_resync
  import lmfr_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  lmfr_in_if.sink    in_ch,
  lmfr_out_if.source out_ch,
  lmfr_cfg_if.sink   cfg_ch
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SCAN,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // ---------------------------------------------------------------- state
  logic [LEN_W-1:0]       total_length_r;
  phase_t                 phase_r,   phase_nxt;
  logic [BYTE_W-1:0]      pend0_r,   pend0_nxt;
  logic [BYTE_W-1:0]      pend1_r,   pend1_nxt;
  logic [1:0]             pcount_r,  pcount_nxt;
  logic [LEN_W-1:0]       pos_r,     pos_nxt;
  logic [SIZE_W-1:0]      pleft_r,   pleft_nxt;
  logic                   defs_r,    defs_nxt;
  logic [COUNT_WIDTH-1:0] vcnt_r,    vcnt_nxt;
  logic [COUNT_WIDTH-1:0] icnt_r,    icnt_nxt;
  status_t                status_r,  status_nxt;

  // result register: one group of up to four beats, shifted out lane 0 first
  logic                          grp_valid_r;
  logic [BEAT_CNT_W-1:0]         grp_left_r,  grp_left_nxt;   // beats after this one
  logic [MAX_BEATS*BYTE_W-1:0]   grp_byte_r,  grp_byte_nxt;
  logic [MAX_BEATS-1:0]          grp_bv_r,    grp_bv_nxt;
  logic                          grp_ms_r,    grp_ms_nxt;
  logic [BYTE_W-1:0]             grp_kind_r,  grp_kind_nxt;
  logic                          grp_sk_r,    grp_sk_nxt;

  // ---------------------------------------------------------------- view
  // a first byte sees the restarted state
  phase_t                 e_phase;
  logic [1:0]             e_pcount;
  logic [LEN_W-1:0]       e_pos;
  logic [SIZE_W-1:0]      e_pleft;
  logic                   e_defs;
  logic [COUNT_WIDTH-1:0] e_vcnt;
  logic [COUNT_WIDTH-1:0] e_icnt;
  status_t                e_status;

  logic [LEN_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  unc;        // bytes after this one
  logic [SIZE_W-1:0] msg_size;
  logic [SIZE_W-1:0] pleft_dec;
  hdr_chk_t          chk;

  logic in_fire;
  logic out_fire;
  logic grp_last;

  // end check for the given held count and unconsumed bytes
  function automatic status_t end_code(input logic [1:0] pc, input logic [LEN_W-1:0] u);
    logic [2:0] rem;
    rem = {1'b0, pc} + {1'b0, u[1:0]};
    if (u >= 32'd3)        end_code = ST_RUNNING;
    else if (rem == 3'd0)  end_code = ST_CLEAN_END;
    else if (rem < 3'd3)   end_code = ST_SHORT_TAIL;
    else                   end_code = ST_RUNNING;
  endfunction

  always_comb begin
    if (in_ch.first) begin
      e_phase  = PH_HEADER;
      e_pcount = '0;
      e_pos    = '0;
      e_pleft  = '0;
      e_defs   = 1'b1;
      e_vcnt   = '0;
      e_icnt   = '0;
      e_status = ST_RUNNING;
    end else begin
      e_phase  = phase_r;
      e_pcount = pcount_r;
      e_pos    = pos_r;
      e_pleft  = pleft_r;
      e_defs   = defs_r;
      e_vcnt   = vcnt_r;
      e_icnt   = icnt_r;
      e_status = status_r;
    end
  end

  assign pos_inc   = e_pos + 32'd1;
  assign unc       = (total_length_r > pos_inc) ? (total_length_r - pos_inc) : '0;
  assign msg_size  = {pend1_r, pend0_r};
  assign pleft_dec = (e_pleft != '0) ? (e_pleft - 16'd1) : e_pleft;

  lmfr_hdr_check u_hdr_check (
    .size (msg_size),
    .kind (in_ch.data_byte),
    .defs (e_defs),
    .chk  (chk)
  );

  // ---------------------------------------------------------------- step
  always_comb begin
    status_t ec;

    phase_nxt  = e_phase;
    pend0_nxt  = pend0_r;
    pend1_nxt  = pend1_r;
    pcount_nxt = e_pcount;
    pos_nxt    = e_pos;
    pleft_nxt  = e_pleft;
    defs_nxt   = e_defs;
    vcnt_nxt   = e_vcnt;
    icnt_nxt   = e_icnt;
    status_nxt = e_status;

    // default group: one beat carrying no byte
    grp_left_nxt = '0;
    grp_byte_nxt = '0;
    grp_bv_nxt   = '0;
    grp_ms_nxt   = 1'b0;
    grp_kind_nxt = '0;
    grp_sk_nxt   = 1'b0;
    ec           = ST_RUNNING;

    unique case (e_phase)
      PH_HEADER: begin
        if (total_length_r < FILE_HDR_LEN) begin
          status_nxt = ST_TOO_SHORT;
          phase_nxt  = PH_DONE;
        end else if (e_pos < MAGIC_LEN) begin
          if (in_ch.data_byte != magic_byte(e_pos[1:0])) begin
            status_nxt = ST_BAD_MAGIC;
            phase_nxt  = PH_DONE;
          end else begin
            pos_nxt = pos_inc;
            // magic held until complete, then released as four beats
            if (pos_inc == MAGIC_LEN) begin
              grp_left_nxt = BEAT_CNT_W'(MAX_BEATS - 1);
              grp_byte_nxt = MAGIC_WORD;
              grp_bv_nxt   = '1;
            end
          end
        end else begin
          grp_byte_nxt[BYTE_W-1:0] = in_ch.data_byte;
          grp_bv_nxt[0]            = 1'b1;
          pos_nxt                  = pos_inc;
          if (pos_inc >= FILE_HDR_LEN) begin
            phase_nxt  = PH_SCAN;
            pcount_nxt = '0;
            ec         = end_code(2'd0, unc);
            if (ec != ST_RUNNING) begin
              status_nxt = ec;
              phase_nxt  = PH_DONE;
            end
          end
        end
      end

      PH_SCAN: begin
        pos_nxt = pos_inc;
        if (e_pcount < PEND_FULL) begin
          // collect the size bytes
          if (e_pcount[0]) pend1_nxt = in_ch.data_byte;
          else             pend0_nxt = in_ch.data_byte;
          pcount_nxt = e_pcount + 2'd1;
        end else if (unc < {16'd0, msg_size}) begin
          status_nxt = ST_TRUNCATED;
          phase_nxt  = PH_DONE;
        end else if (!chk.ok) begin
          // drop the oldest held byte and rescan one byte later
          defs_nxt   = chk.defs_nxt;
          if (e_icnt != CNT_MAX) icnt_nxt = e_icnt + COUNT_WIDTH'(1);
          grp_sk_nxt = 1'b1;
          pend0_nxt  = pend1_r;
          pend1_nxt  = in_ch.data_byte;
          pcount_nxt = PEND_FULL;
          ec         = end_code(PEND_FULL, unc);
          if (ec != ST_RUNNING) begin
            status_nxt = ec;
            phase_nxt  = PH_DONE;
          end
        end else begin
          defs_nxt = chk.defs_nxt;
          if (e_vcnt != CNT_MAX) vcnt_nxt = e_vcnt + COUNT_WIDTH'(1);
          grp_left_nxt = BEAT_CNT_W'(2);
          grp_byte_nxt = {8'd0, in_ch.data_byte, pend1_r, pend0_r};
          grp_bv_nxt   = 4'b0111;
          grp_ms_nxt   = 1'b1;
          grp_kind_nxt = in_ch.data_byte;
          pcount_nxt   = '0;
          if (msg_size != '0) begin
            phase_nxt = PH_PAYLOAD;
            pleft_nxt = msg_size;
          end else begin
            ec = end_code(2'd0, unc);
            if (ec != ST_RUNNING) begin
              status_nxt = ec;
              phase_nxt  = PH_DONE;
            end
          end
        end
      end

      PH_PAYLOAD: begin
        grp_byte_nxt[BYTE_W-1:0] = in_ch.data_byte;
        grp_bv_nxt[0]            = 1'b1;
        pos_nxt                  = pos_inc;
        pleft_nxt                = pleft_dec;
        if (pleft_dec == '0) begin
          phase_nxt  = PH_SCAN;
          pcount_nxt = '0;
          ec         = end_code(2'd0, unc);
          if (ec != ST_RUNNING) begin
            status_nxt = ec;
            phase_nxt  = PH_DONE;
          end
        end
      end

      PH_DONE: begin
        // bytes ignored until a first byte restarts the parse
      end

      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign grp_last     = (grp_left_r == '0);
  assign out_fire     = out_ch.valid && out_ch.ready;
  // a new byte loads while the last beat of the previous group leaves
  assign in_ch.ready  = !grp_valid_r || (out_ch.ready && grp_last);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r <= '0;
      phase_r        <= PH_HEADER;
      pcount_r       <= '0;
      pos_r          <= '0;
      pleft_r        <= '0;
      defs_r         <= 1'b1;
      vcnt_r         <= '0;
      icnt_r         <= '0;
      status_r       <= ST_RUNNING;
      grp_valid_r    <= 1'b0;
      grp_left_r     <= '0;
    end else begin
      if (cfg_ch.valid) begin
        total_length_r <= cfg_ch.total_length;
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        pcount_r    <= pcount_nxt;
        pos_r       <= pos_nxt;
        pleft_r     <= pleft_nxt;
        defs_r      <= defs_nxt;
        vcnt_r      <= vcnt_nxt;
        icnt_r      <= icnt_nxt;
        status_r    <= status_nxt;
        grp_valid_r <= 1'b1;
        grp_left_r  <= grp_left_nxt;
      end else if (out_fire) begin
        if (grp_last) begin
          grp_valid_r <= 1'b0;
        end else begin
          grp_left_r <= grp_left_r - BEAT_CNT_W'(1);
        end
      end
    end
  end

  // payload side of the state and result register, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend0_r    <= pend0_nxt;
      pend1_r    <= pend1_nxt;
      grp_byte_r <= grp_byte_nxt;
      grp_bv_r   <= grp_bv_nxt;
      grp_ms_r   <= grp_ms_nxt;
      grp_kind_r <= grp_kind_nxt;
      grp_sk_r   <= grp_sk_nxt;
    end else if (out_fire && !grp_last) begin
      // next beat moves into lane 0; start flag and kind belong to the first only
      grp_byte_r <= {8'd0, grp_byte_r[MAX_BEATS*BYTE_W-1:BYTE_W]};
      grp_bv_r   <= {1'b0, grp_bv_r[MAX_BEATS-1:1]};
      grp_ms_r   <= 1'b0;
      grp_kind_r <= '0;
    end
  end

  // ---------------------------------------------------------------- outputs
  // status and counters show the state after the byte that made the group
  assign out_ch.valid         = grp_valid_r;
  assign out_ch.out_byte      = grp_byte_r[BYTE_W-1:0];
  assign out_ch.byte_valid    = grp_bv_r[0];
  assign out_ch.message_start = grp_ms_r;
  assign out_ch.message_kind  = grp_kind_r;
  assign out_ch.skipped       = grp_sk_r;
  assign out_ch.status        = status_r;
  assign out_ch.msg_count     = OUT_CNT_W'(vcnt_r);
  assign out_ch.skip_count    = OUT_CNT_W'(icnt_r);
  assign out_ch.last          = grp_last;

endmodule

[rtl/lmfr_hdr_check.sv]
// ----------------------------------------------------------------------------
// lmfr_hdr_check
// Checks a message header's type letter and size against the section rules.
// ----------------------------------------------------------------------------
module lmfr_hdr_check
  import lmfr_pkg::*;
(
  input  logic [SIZE_W-1:0] size,
  input  logic [BYTE_W-1:0] kind,
  input  logic              defs,
  output hdr_chk_t          chk
);

  logic known;
  logic ends_defs;
  logic defs_nxt;
  logic defs_type;
  logic late_banned;
  logic section_ok;
  logic size_ok;

  always_comb begin
    known = (kind == T_A) || (kind == T_B) || (kind == T_C) || (kind == T_D) ||
            (kind == T_F) || (kind == T_I) || (kind == T_L) || (kind == T_M) ||
            (kind == T_O) || (kind == T_P) || (kind == T_Q) || (kind == T_R) ||
            (kind == T_S);
    ends_defs   = (kind == T_A) || (kind == T_L);
    defs_nxt    = defs && !ends_defs;
    defs_type   = (kind == T_B) || (kind == T_F) || (kind == T_I) ||
                  (kind == T_M) || (kind == T_P) || (kind == T_Q);
    late_banned = (kind == T_B) || (kind == T_F);
    section_ok  = defs_nxt ? defs_type : !late_banned;

    if (kind == T_B)      size_ok = (size == SIZE_B_EQ);
    else if (kind == T_C) size_ok = (size >= SIZE_C_MIN);
    else if (kind == T_D) size_ok = (size >= SIZE_D_MIN);
    else if (kind == T_L) size_ok = (size >= SIZE_L_MIN);
    else if (kind == T_O) size_ok = (size == SIZE_O_EQ);
    else if (kind == T_R) size_ok = (size == SIZE_R_EQ);
    else if (kind == T_S) size_ok = (size == SIZE_S_EQ);
    else                  size_ok = (size >= SIZE_DEF_MIN);

    chk.ok       = known && section_ok && size_ok;
    chk.defs_nxt = defs_nxt;
  end

endmodule

[rtl/lmfr_checker.sv]
// ----------------------------------------------------------------------------
// lmfr_checker
// Port-level checks on the framer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lmfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic        message_start,
  input logic [7:0]  message_kind,
  input logic        skipped,
  input logic        last
);

  // a stalled beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // a beat without a stream byte is the only beat of its byte and carries zero
  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> last && (out_byte == 8'd0))
    else $error("empty beat is not a lone final beat");

  // a message start opens a three-beat header and names a type
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_start |-> byte_valid && !last && (message_kind != 8'd0))
    else $error("message start on a bad beat");

  // a rejected header passes no byte
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && skipped |-> !byte_valid && !message_start)
    else $error("skipped header carried a byte");

endmodule

bind log_message_framer_resync lmfr_checker u_lmfr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .byte_valid    (out_ch.byte_valid),
  .message_start (out_ch.message_start),
  .message_kind  (out_ch.message_kind),
  .skipped       (out_ch.skipped),
  .last          (out_ch.last)
);

[tb/tb_log_message_framer_resync.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_message_framer_resync
// Self-checking bench for the log message framer. Log files are fed one byte
// per beat, a few known bytes first and then generated files with random
// messages, junk and bad lengths. Each result beat is checked against an
// in-bench model of the framer, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_log_message_framer_resync;
  import lmfr_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on any channel
  localparam int RAND_BYTES   = 270;   // input bytes in the random part
  localparam int DIR_ROWS     = 26;

  // parser phases of the in-bench framer model
  typedef enum logic [1:0] {
    FR_FILE_HDR,
    FR_SCAN,
    FR_BODY,
    FR_STOPPED
  } fr_phase_t;

  // one beat of the result channel
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        message_start;
    logic [7:0]  message_kind;
    logic        skipped;
    status_t     status;
    logic [31:0] msg_count;
    logic [31:0] skip_count;
    logic        last;
  } beat_t;

  // directed stimulus row: optional length write, then one byte
  typedef struct {
    bit          set_len;
    logic [31:0] len;
    logic [7:0]  data;
    bit          restart;
    bit          pinned;     // expected beat typed in below, not predicted
    status_t     pin_status;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lmfr_in_if  in_if ();
  lmfr_out_if out_if ();
  lmfr_cfg_if cfg_if ();

  log_message_framer_resync uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // framer model state
  // --------------------------------------------------------------------------
  logic [31:0] file_len;
  fr_phase_t   fr_phase;
  logic [7:0]  held_byte [2];   // size bytes waiting for their type letter
  logic [1:0]  held_cnt;
  logic [31:0] bytes_seen;      // file bytes consumed so far
  logic [15:0] body_left;       // payload bytes still to copy
  logic        in_defs;         // still in the definitions section
  logic [31:0] good_msgs;
  logic [31:0] bad_msgs;
  status_t     end_code;

  beat_t       framed_beats_due [$];   // beats still owed by the framer

  int          mismatches;
  int          beats_checked;
  int          bytes_parsed;   // input bytes sent
  int          press_mode;     // 0 no idling, 1 heavy, 2 light
  int          hold_left;      // result channel stall cycles still to go
  int          quiet_cycles;
  logic [7:0]  file_img [$];   // generated log file
  dir_row_t    dir_rows [DIR_ROWS];

  function automatic void clear_parse();
    fr_phase    = FR_FILE_HDR;
    held_byte[0] = '0;
    held_byte[1] = '0;
    held_cnt    = '0;
    bytes_seen  = '0;
    body_left   = '0;
    in_defs     = 1'b1;
    good_msgs   = '0;
    bad_msgs    = '0;
    end_code    = ST_RUNNING;
  endfunction

  function automatic void stop_parse(status_t code);
    end_code = code;
    fr_phase = FR_STOPPED;
  endfunction

  function automatic logic [31:0] bytes_left();
    return (file_len > bytes_seen) ? file_len - bytes_seen : 32'd0;
  endfunction

  // run out of file where a message header would begin
  function automatic void close_if_ending();
    logic [33:0] rem;
    rem = {32'd0, held_cnt} + {2'd0, bytes_left()};
    if (rem == 0)
      stop_parse(ST_CLEAN_END);
    else if (rem < 3)
      stop_parse(ST_SHORT_TAIL);
  endfunction

  // type and size rules; A or L closes the definitions section first
  function automatic logic header_accepted(logic [15:0] size, logic [7:0] t);
    logic known;
    case (t)
      T_A, T_B, T_C, T_D, T_F, T_I, T_L, T_M, T_O, T_P, T_Q, T_R, T_S: known = 1'b1;
      default: known = 1'b0;
    endcase
    if (!known)
      return 1'b0;
    if (t == T_A || t == T_L)
      in_defs = 1'b0;
    if (in_defs) begin
      if (!(t == T_B || t == T_F || t == T_I || t == T_M || t == T_P || t == T_Q))
        return 1'b0;
    end else if (t == T_B || t == T_F) begin
      return 1'b0;
    end
    case (t)
      T_B: return size == SIZE_B_EQ;
      T_C: return size >= SIZE_C_MIN;
      T_D: return size >= SIZE_D_MIN;
      T_L: return size >= SIZE_L_MIN;
      T_O: return size == SIZE_O_EQ;
      T_R: return size == SIZE_R_EQ;
      T_S: return size == SIZE_S_EQ;
      default: return size >= SIZE_DEF_MIN;
    endcase
  endfunction

  // advance the model by one accepted byte and queue the beats it owes
  task automatic frame_byte(input logic [7:0] b, input bit restart);
    beat_t       beats [4];
    int          n;
    logic        sk;
    logic [15:0] size;
    n = 0;
    sk = 1'b0;
    for (int k = 0; k < 4; k++)
      beats[k] = '0;
    if (restart)
      clear_parse();
    case (fr_phase)
      FR_FILE_HDR: begin
        if (file_len < FILE_HDR_LEN) begin
          stop_parse(ST_TOO_SHORT);
        end else if (bytes_seen < MAGIC_LEN) begin
          if (b != MAGIC_WORD[bytes_seen[1:0]*8 +: 8]) begin
            stop_parse(ST_BAD_MAGIC);
          end else begin
            bytes_seen++;
            // magic bytes are held back and released together
            if (bytes_seen == MAGIC_LEN) begin
              for (int k = 0; k < 4; k++) begin
                beats[k].out_byte   = MAGIC_WORD[k*8 +: 8];
                beats[k].byte_valid = 1'b1;
              end
              n = 4;
            end
          end
        end else begin
          beats[0].out_byte   = b;
          beats[0].byte_valid = 1'b1;
          n = 1;
          bytes_seen++;
          if (bytes_seen >= FILE_HDR_LEN) begin
            fr_phase = FR_SCAN;
            held_cnt = '0;
            close_if_ending();
          end
        end
      end
      FR_SCAN: begin
        bytes_seen++;
        if (held_cnt < PEND_FULL) begin
          held_byte[held_cnt[0]] = b;
          held_cnt++;
        end else begin
          size = {held_byte[1], held_byte[0]};
          if (bytes_left() < {16'd0, size}) begin
            stop_parse(ST_TRUNCATED);
          end else if (!header_accepted(size, b)) begin
            // drop the oldest header byte and look one byte later
            if (bad_msgs != '1)
              bad_msgs++;
            sk = 1'b1;
            held_byte[0] = held_byte[1];
            held_byte[1] = b;
            held_cnt = PEND_FULL;
            close_if_ending();
          end else begin
            if (good_msgs != '1)
              good_msgs++;
            beats[0].out_byte = held_byte[0];
            beats[1].out_byte = held_byte[1];
            beats[2].out_byte = b;
            for (int k = 0; k < 3; k++)
              beats[k].byte_valid = 1'b1;
            beats[0].message_start = 1'b1;
            beats[0].message_kind  = b;
            n = 3;
            held_cnt = '0;
            if (size != 0) begin
              fr_phase  = FR_BODY;
              body_left = size;
            end else begin
              close_if_ending();
            end
          end
        end
      end
      FR_BODY: begin
        beats[0].out_byte   = b;
        beats[0].byte_valid = 1'b1;
        n = 1;
        bytes_seen++;
        if (body_left > 0)
          body_left--;
        if (body_left == 0) begin
          fr_phase = FR_SCAN;
          held_cnt = '0;
          close_if_ending();
        end
      end
      default: ;
    endcase
    if (n == 0)
      n = 1;
    for (int k = 0; k < n; k++) begin
      beats[k].skipped    = sk;
      beats[k].status     = end_code;
      beats[k].msg_count  = good_msgs;
      beats[k].skip_count = bad_msgs;
      beats[k].last       = (k == n - 1);
      framed_beats_due.push_back(beats[k]);
    end
  endtask

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  function automatic int draw_wait();
    case (press_mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  // one input beat; called at a falling edge, returns at a falling edge with
  // valid still high, so the next call or an idle wait decides what follows
  task automatic push_byte(input logic [7:0] b, input bit restart, input bit pinned,
                           input status_t pin_status);
    int    gap;
    beat_t typed;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.first     = restart;
    do @(posedge clk); while (!in_if.ready);
    frame_byte(b, restart);
    if (pinned) begin
      // plain status beat: nothing passed, counters at zero
      typed        = '0;
      typed.status = pin_status;
      typed.last   = 1'b1;
      void'(framed_beats_due.pop_back());
      framed_beats_due.push_back(typed);
    end
    bytes_parsed++;
    @(negedge clk);
  endtask

  // block idle: every owed beat delivered plus a few cycles of margin
  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (framed_beats_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_file_len(input logic [31:0] len);
    wait_idle();
    cfg_if.valid        = 1'b1;
    cfg_if.total_length = len;
    do @(posedge clk); while (!cfg_if.ready);
    file_len = len;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // generated log file: magic, header, a run of messages with random content,
  // now and then junk bytes, a broken header or a damaged magic byte
  task automatic build_random_file(output logic [31:0] len);
    int         nmsg;
    int         size;
    int         actual;
    bit         defs;
    logic [7:0] t;
    file_img.delete();
    for (int k = 0; k < 4; k++)
      file_img.push_back(MAGIC_WORD[k*8 +: 8]);
    if ($urandom_range(0, 11) == 0)
      file_img[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
    repeat (12) file_img.push_back(8'($urandom));
    defs = 1'b1;
    nmsg = $urandom_range(1, 5);
    for (int i = 0; i < nmsg; i++) begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) file_img.push_back(8'($urandom));
      if (defs && (i == nmsg - 1 || $urandom_range(0, 2) == 0)) begin
        t = $urandom_range(0, 1) ? T_A : T_L;
      end else if (defs) begin
        case ($urandom_range(0, 9))
          0: t = T_B;
          1: t = T_F;
          2, 3: t = T_I;
          4, 5: t = T_M;
          6, 7: t = T_P;
          default: t = T_Q;
        endcase
      end else begin
        case ($urandom_range(0, 10))
          0: t = T_C;
          1: t = T_D;
          2: t = T_I;
          3: t = T_L;
          4: t = T_M;
          5: t = T_O;
          6: t = T_P;
          7: t = T_Q;
          8: t = T_R;
          9: t = T_S;
          default: t = T_A;
        endcase
      end
      if (t == T_A || t == T_L)
        defs = 1'b0;
      case (t)
        T_B: size = SIZE_B_EQ;
        T_C: size = SIZE_C_MIN + $urandom_range(0, 6);
        T_D: size = SIZE_D_MIN + $urandom_range(0, 6);
        T_L: size = SIZE_L_MIN + $urandom_range(0, 6);
        T_O, T_R: size = SIZE_O_EQ;
        T_S: size = SIZE_S_EQ;
        default: size = SIZE_DEF_MIN + $urandom_range(0, 6);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        // broken header: any type, any size, short random tail
        if ($urandom_range(0, 1))
          t = 8'($urandom);
        size = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
        file_img.push_back(size[7:0]);
        file_img.push_back(size[15:8]);
        file_img.push_back(t);
        repeat ($urandom_range(0, 8)) file_img.push_back(8'($urandom));
      end else begin
        file_img.push_back(size[7:0]);
        file_img.push_back(size[15:8]);
        file_img.push_back(t);
        repeat (size) file_img.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 2)) file_img.push_back(8'($urandom));
    actual = file_img.size();
    case ($urandom_range(0, 19))
      0: len = $urandom_range(0, 15);
      1: len = actual - 1;
      2: len = actual - 2;
      3: len = actual + 1;
      4: len = actual + 2;
      5: len = actual - $urandom_range(3, 20);
      default: len = actual;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // result channel: stalls and checking
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch at beat %0d, %s: got %0h, want %0h", beats_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (framed_beats_due.size() == 0) begin
        note_mismatch("beat with nothing owed", 32'(out_if.out_byte), 32'd0);
      end else begin
        want = framed_beats_due.pop_front();
        if (out_if.out_byte !== want.out_byte)
          note_mismatch("out_byte", 32'(out_if.out_byte), 32'(want.out_byte));
        if (out_if.byte_valid !== want.byte_valid)
          note_mismatch("byte_valid", 32'(out_if.byte_valid), 32'(want.byte_valid));
        if (out_if.message_start !== want.message_start)
          note_mismatch("message_start", 32'(out_if.message_start),
                        32'(want.message_start));
        if (out_if.message_kind !== want.message_kind)
          note_mismatch("message_kind", 32'(out_if.message_kind),
                        32'(want.message_kind));
        if (out_if.skipped !== want.skipped)
          note_mismatch("skipped", 32'(out_if.skipped), 32'(want.skipped));
        if (out_if.status !== want.status)
          note_mismatch("status", 32'(out_if.status), 32'(want.status));
        if (out_if.msg_count !== want.msg_count)
          note_mismatch("msg_count", out_if.msg_count, want.msg_count);
        if (out_if.skip_count !== want.skip_count)
          note_mismatch("skip_count", out_if.skip_count, want.skip_count);
        if (out_if.last !== want.last)
          note_mismatch("last", 32'(out_if.last), 32'(want.last));
      end
      beats_checked++;
      hold_left = draw_wait();
    end
  end

  // watchdog: a hung handshake on any channel ends the run
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] len;
    int          cut;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.first         = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.total_length = '0;
    mismatches    = 0;
    beats_checked = 0;
    bytes_parsed  = 0;
    quiet_cycles  = 0;
    press_mode    = 2;
    file_len      = '0;
    clear_parse();

    // directed rows; 55 4C 6F 67 spell the magic
    dir_rows = '{
      // length zero: file too short on the first header byte
      '{1'b1, 32'd0,          8'h55, 1'b1, 1'b1, ST_TOO_SHORT},
      // longest length, wrong first magic byte
      '{1'b1, 32'hFFFF_FFFF,  8'h00, 1'b1, 1'b1, ST_BAD_MAGIC},
      // restart, bad magic on the third byte, then a byte after the end
      '{1'b0, 32'd0,          8'h55, 1'b1, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h4C, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'hFF, 1'b0, 1'b1, ST_BAD_MAGIC},
      '{1'b0, 32'd0,          8'h55, 1'b0, 1'b1, ST_BAD_MAGIC},
      // 24 byte file: full header with extreme bytes
      '{1'b1, 32'd24,         8'h55, 1'b1, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h4C, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h6F, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h67, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'hFF, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h00, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h80, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h7F, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h01, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'hFE, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'hAA, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h55, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h0F, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'hF0, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h00, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'hFF, 1'b0, 1'b0, ST_RUNNING},
      // size 0 with type A: rejected, yet the definitions section ends
      '{1'b0, 32'd0,          8'h00, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          8'h00, 1'b0, 1'b0, ST_RUNNING},
      '{1'b0, 32'd0,          T_A,   1'b0, 1'b0, ST_RUNNING},
      // rescan sees size 0x4100, more than is left: truncated message
      '{1'b0, 32'd0,          8'h00, 1'b0, 1'b0, ST_RUNNING}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].set_len)
        set_file_len(dir_rows[r].len);
      push_byte(dir_rows[r].data, dir_rows[r].restart, dir_rows[r].pinned,
                dir_rows[r].pin_status);
    end

    // random files, each under its own length and idling mix
    bytes_parsed = 0;
    while (bytes_parsed < RAND_BYTES) begin
      build_random_file(len);
      set_file_len(len);
      press_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        // part of the file, then start over from its first byte
        cut = $urandom_range(1, file_img.size() - 1);
        for (int i = 0; i < cut; i++)
          push_byte(file_img[i], i == 0, 1'b0, ST_RUNNING);
      end
      for (int i = 0; i < file_img.size(); i++)
        push_byte(file_img[i], i == 0, 1'b0, ST_RUNNING);
    end

    in_if.valid = 1'b0;
    while (framed_beats_due.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (framed_beats_due.size() != 0)
      note_mismatch("beats never delivered", framed_beats_due.size(), 32'd0);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[log_message_framer_resync.f]
rtl/lmfr_pkg.sv
rtl/lmfr_in_if.sv
rtl/lmfr_out_if.sv
rtl/lmfr_cfg_if.sv
rtl/lmfr_hdr_check.sv
rtl/log_message_framer_resync.sv
rtl/lmfr_checker.sv
tb/tb_log_message_framer_resync.sv
